// ===== rtl/radial_distance_alpha_mask_defines.svh =====
// Assertion macros for the radial distance alpha mask.
`ifndef RADIAL_DISTANCE_ALPHA_MASK_DEFINES_SVH
`define RADIAL_DISTANCE_ALPHA_MASK_DEFINES_SVH
// Asserts that a consequent follows an antecedent on the same edge.
`define RDAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Asserts that a consequent follows an antecedent on the next edge.
`define RDAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/rdam_pkg.sv =====
// ----------------------------------------------------------------------------
// rdam_pkg
// Shared constants and types of the radial distance alpha mask.
// ----------------------------------------------------------------------------
`default_nettype none
package rdam_pkg;
    localparam int MAX_RADIUS = 1023;
    localparam int RAD_W = 10;
    localparam int COORD_W = 10;
    localparam int Q_W = 16;
    localparam int SQ_W = 21;           // x*x + y*y
    localparam int RAD_IN_W = 52;       // radicand = sum << 30, even width
    localparam int ROOT_W = 26;
    localparam int DIV_NUM_W = 32;      // divider dividend / quotient width
    localparam int DIV_DEN_W = 16;      // divider divisor width
    localparam int DIV_SB_W = 1 + 2 + Q_W;
    localparam logic [Q_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic [2:0] CFG_RADIUS = 3'd0;
    localparam logic [2:0] CFG_INVERT = 3'd1;
    localparam logic [2:0] CFG_SMOOTH = 3'd2;
    localparam logic [2:0] CFG_ELOW   = 3'd3;
    localparam logic [2:0] CFG_EHIGH  = 3'd4;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic             invert;
        logic             smooth;
        logic [Q_W-1:0]   edge_low;
        logic [Q_W-1:0]   edge_high;
    } t_cfg;
endpackage
`default_nettype wire

// ===== rtl/rdam_sqrt.sv =====
// ----------------------------------------------------------------------------
// rdam_sqrt
// Pipelined integer square root of (x*x + y*y) << 30, one root bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rdam_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [rdam_pkg::COORD_W-1:0]  i_px,
    input  wire logic [rdam_pkg::COORD_W-1:0]  i_py,
    output logic                               o_valid,
    output logic [rdam_pkg::ROOT_W-1:0]        o_root
);
    import rdam_pkg::*;
    localparam int NST = ROOT_W;
    localparam int RW = ROOT_W + 2;

    logic [SQ_W-1:0] r_sum;
    logic            r_sv;
    logic [NST:0]    r_v;
    logic [RAD_IN_W-1:0] r_n   [NST+1];
    logic [RW-1:0]       r_rem [NST+1];
    logic [ROOT_W-1:0]   r_q   [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r_sv <= i_valid;
            r_v  <= {r_v[NST-1:0], r_sv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SQ_W'(i_px * i_px) + SQ_W'(i_py * i_py);
            r_n[0] <= RAD_IN_W'({r_sum, 30'd0});
            r_rem[0] <= '0;
            r_q[0] <= '0;
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [RW-1:0] w_trial, w_cur;
        logic [ROOT_W-1:0] w_q;
        always_comb begin
            w_cur = {r_rem[g][RW-3:0], r_n[g][RAD_IN_W-1 -: 2]};
            w_trial = RW'({r_q[g], 2'b01});
            w_q = {r_q[g][ROOT_W-2:0], 1'b0};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g+1] <= {r_n[g][RAD_IN_W-3:0], 2'b00};
                if (w_cur >= w_trial) begin
                    r_rem[g+1] <= w_cur - w_trial;
                    r_q[g+1] <= w_q | ROOT_W'(1);
                end else begin
                    r_rem[g+1] <= w_cur;
                    r_q[g+1] <= w_q;
                end
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_root = r_q[NST];
endmodule
`default_nettype wire

// ===== rtl/rdam_div.sv =====
// ----------------------------------------------------------------------------
// rdam_div
// Pipelined restoring divider, one quotient bit a stage, with a sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module rdam_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [rdam_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [rdam_pkg::DIV_DEN_W-1:0]  i_den,
    input  wire logic [rdam_pkg::DIV_SB_W-1:0]   i_sb,
    output logic                                 o_valid,
    output logic [rdam_pkg::DIV_NUM_W-1:0]       o_quo,
    output logic [rdam_pkg::DIV_SB_W-1:0]        o_sb
);
    import rdam_pkg::*;
    localparam int RW = DIV_DEN_W + 1;
    logic [DIV_NUM_W:0]   r_v;
    logic [DIV_NUM_W-1:0] r_n  [DIV_NUM_W+1];
    logic [RW-1:0]        r_r  [DIV_NUM_W+1];
    logic [DIV_DEN_W-1:0] r_d  [DIV_NUM_W+1];
    logic [DIV_SB_W-1:0]  r_s  [DIV_NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[DIV_NUM_W-1:0], i_valid};
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= i_num;
            r_r[0] <= '0;
            r_d[0] <= i_den;
            r_s[0] <= i_sb;
        end
    end
    for (genvar g = 0; g < DIV_NUM_W; g++) begin : g_st
        logic [RW:0] w_c;
        assign w_c = {r_r[g], r_n[g][DIV_NUM_W-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g+1] <= r_d[g];
                r_s[g+1] <= r_s[g];
                if (w_c >= {1'b0, 1'b0, r_d[g]}) begin
                    r_r[g+1] <= RW'(w_c - {2'b00, r_d[g]});
                    r_n[g+1] <= {r_n[g][DIV_NUM_W-2:0], 1'b1};
                end else begin
                    r_r[g+1] <= RW'(w_c);
                    r_n[g+1] <= {r_n[g][DIV_NUM_W-2:0], 1'b0};
                end
            end
        end
    end
    assign o_valid = r_v[DIV_NUM_W];
    assign o_quo = r_n[DIV_NUM_W];
    assign o_sb = r_s[DIV_NUM_W];
endmodule
`default_nettype wire

// ===== rtl/radial_distance_alpha_mask.sv =====
// ----------------------------------------------------------------------------
// radial_distance_alpha_mask
// Brush alpha from a pixel offset: radial distance, inversion, smoothstep.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tdata[9:0] px, tdata[19:10] py
// m_axis    out        tdata[15:0] alpha, tuser outside
// cfg       in         index 3 bits, data 16 bits
// One word enters and one leaves each cycle while the output is not stalled,
// through 98 register stages: 28 in the square root, 33 in each divider, one
// for the base value and three for the polynomial.
// Reset is synchronous and active low and restores the register defaults.
// A stall at the output freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radial_distance_alpha_mask_defines.svh"
module radial_distance_alpha_mask (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // px, py
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // alpha
    output logic             m_axis_tuser,   // outside
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import rdam_pkg::*;

    t_cfg r_cfg;
    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{radius: RAD_W'(1), invert: 1'b0, smooth: 1'b0,
                       edge_low: '0, edge_high: ONE_Q15};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS: r_cfg.radius <= i_cfg_data[RAD_W-1:0];
                CFG_INVERT: r_cfg.invert <= i_cfg_data[0];
                CFG_SMOOTH: r_cfg.smooth <= i_cfg_data[0];
                CFG_ELOW:   r_cfg.edge_low <= i_cfg_data;
                CFG_EHIGH:  r_cfg.edge_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_rt_v;
    logic [ROOT_W-1:0] w_root;
    rdam_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(s_axis_tvalid),
        .i_px(s_axis_tdata[9:0]), .i_py(s_axis_tdata[19:10]),
        .o_valid(w_rt_v), .o_root(w_root)
    );

    logic [RAD_W-1:0] w_rad;
    assign w_rad = (r_cfg.radius == '0) ? RAD_W'(1) : r_cfg.radius;

    logic w_d_v;
    logic [DIV_NUM_W-1:0] w_v;
    logic [DIV_SB_W-1:0] w_v_sb;
    rdam_div u_vdiv (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_rt_v), .i_num(DIV_NUM_W'(w_root)),
        .i_den(DIV_DEN_W'(w_rad)), .i_sb(DIV_SB_W'(r_cfg.invert)),
        .o_valid(w_d_v), .o_quo(w_v), .o_sb(w_v_sb)
    );

    // Base value and smoothstep region select.
    logic r_b_v, r_b_out;
    logic [Q_W-1:0] r_base;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (w_en) r_b_v <= w_d_v;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_out <= w_v > DIV_NUM_W'(ONE_Q15);
            if (w_v > DIV_NUM_W'(ONE_Q15)) r_base <= '0;
            else if (w_v_sb[0]) r_base <= ONE_Q15 - w_v[Q_W-1:0];
            else r_base <= w_v[Q_W-1:0];
        end
    end

    // Sideband: {outside, mode 2 bits, base}; mode 0 smoothstep, 1 zero, 2 one, 3 bypass.
    logic [1:0] w_mode;
    always_comb begin
        if (!r_cfg.smooth) w_mode = 2'd3;
        else if (r_base < r_cfg.edge_low) w_mode = 2'd1;
        else if (r_base >= r_cfg.edge_high) w_mode = 2'd2;
        else w_mode = 2'd0;
    end
    logic [Q_W-1:0] w_den;
    assign w_den = r_cfg.edge_high - r_cfg.edge_low;
    logic [31:0] w_tnum;
    assign w_tnum = {1'b0, 16'(r_base - r_cfg.edge_low), 15'd0};

    logic w_t_v;
    logic [DIV_NUM_W-1:0] w_t;
    logic [DIV_SB_W-1:0] w_sb;
    rdam_div u_tdiv (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_b_v), .i_num(w_tnum),
        .i_den(w_den), .i_sb({r_b_out, w_mode, r_base}),
        .o_valid(w_t_v), .o_quo(w_t), .o_sb(w_sb)
    );

    // Polynomial: t*t, then times (98304 - 2t), then shift.
    logic r_p1_v, r_p2_v;
    logic [31:0] r_tt;
    logic [17:0] r_k;
    logic [DIV_SB_W-1:0] r_sb1, r_sb2;
    logic [49:0] r_num;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_t_v;
            r_p2_v <= r_p1_v;
            m_axis_tvalid <= r_p2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tt <= 32'(w_t[15:0] * w_t[15:0]);
            r_k <= 18'(18'd98304 - {1'b0, w_t[15:0], 1'b0});
            r_sb1 <= w_sb;
            r_num <= 50'(r_tt * r_k);
            r_sb2 <= r_sb1;
            m_axis_tuser <= r_sb2[DIV_SB_W-1];
            case (r_sb2[DIV_SB_W-2 -: 2])
                2'd0: m_axis_tdata <= r_num[45:30];
                2'd1: m_axis_tdata <= '0;
                2'd2: m_axis_tdata <= ONE_Q15;
                default: m_axis_tdata <= r_sb2[Q_W-1:0];
            endcase
        end
    end

    `RDAM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `RDAM_ASSERT_IMPL(a_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata <= ONE_Q15)
    `RDAM_ASSERT_IMPL(a_out0, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser && !r_cfg.smooth, m_axis_tdata == 16'd0)
endmodule
`default_nettype wire
